// ----- rtl/lpc_pkg.sv -----
// Shared types and constants of the local peak clip filter.
// No dependencies; every rtl file but lpc_queue imports it.
package lpc_pkg;

   localparam int PIX_PORT_BITS  = 32;
   localparam int FW_BITS        = 11;
   localparam int FH_BITS        = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CMD_Q_DEPTH    = 4;
   localparam int RSP_Q_DEPTH    = 2;

   localparam logic [FW_BITS-1:0] FW_RESET = 11'd1024;
   localparam logic [FH_BITS-1:0] FH_RESET = 16'd1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // store: row zero pixel, only buffered; pixel: filters the row above; drain: flushes
   typedef enum logic [1:0] {
      KIND_STORE,
      KIND_PIXEL,
      KIND_DRAIN
   } lpc_kind_type;

   typedef struct packed {
      lpc_kind_type kind;
      logic         has_up;
      logic         has_left;
      logic         has_right;
      logic         last;
   } lpc_ctl_type;

endpackage

// ----- rtl/lpc_queue.sv -----
// Small first-in first-out queue of flat words.
// Used between front and back and as the result skid buffer; uses no package.
module lpc_queue #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on a lone push");

endmodule

// ----- rtl/lpc_front.sv -----
// Front end: configuration registers, raster position and item classification.
// Depends on lpc_pkg; feeds the command queue toward lpc_back.
module lpc_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                req_operation,
   input  logic [lpc_pkg::PIX_PORT_BITS-1:0]   req_pixel_in,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lpc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                cmd_full,
   output logic                                cmd_push,
   output lpc_pkg::lpc_ctl_type                cmd_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]        cmd_col,
   output logic [((PIXEL_BITS < lpc_pkg::PIX_PORT_BITS) ? PIXEL_BITS :
                  lpc_pkg::PIX_PORT_BITS)-1:0] cmd_pix
);

   import lpc_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int DATA_BITS = (PIXEL_BITS < PIX_PORT_BITS) ? PIXEL_BITS : PIX_PORT_BITS;

   logic [FW_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [FH_BITS-1:0]  frame_height_ff, frame_height_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [FH_BITS-1:0]  row_ff, row_in;
   logic [COL_BITS:0]   eff_width;
   logic [FH_BITS-1:0]  eff_height;
   logic [COL_BITS:0]   col_next;
   logic                at_row_end;
   logic                accept;

   assign csr_ready = 1'b1;
   assign accept    = req_push & ~cmd_full;
   assign cmd_col   = col_ff;
   assign cmd_pix   = req_pixel_in[DATA_BITS-1:0];

   // zero width acts as one, oversize width clamps to the buffer depth
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_width = (COL_BITS+1)'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = (COL_BITS+1)'(MAX_WIDTH);
      end else begin
         eff_width = (COL_BITS+1)'(frame_width_ff);
      end
   end

   assign eff_height = (frame_height_ff == '0) ? FH_BITS'(1) : frame_height_ff;
   assign col_next   = {1'b0, col_ff} + 1'b1;
   assign at_row_end = (col_next >= eff_width);

   always_comb begin
      frame_width_in     = frame_width_ff;
      frame_height_in    = frame_height_ff;
      col_in             = col_ff;
      row_in             = row_ff;
      cmd_push           = 1'b0;
      cmd_ctl.kind       = KIND_PIXEL;
      cmd_ctl.has_up     = 1'b0;
      cmd_ctl.has_left   = (col_ff != '0);
      cmd_ctl.has_right  = ~at_row_end;
      cmd_ctl.last       = 1'b0;

      if (accept) begin
         if (req_operation == OP_PIXEL) begin
            // pixels beyond the frame are dropped until it is drained
            if (row_ff < eff_height) begin
               cmd_push       = 1'b1;
               cmd_ctl.kind   = (row_ff == '0) ? KIND_STORE : KIND_PIXEL;
               cmd_ctl.has_up = (row_ff >= FH_BITS'(2));
               if (at_row_end) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_next[COL_BITS-1:0];
               end
            end
         end else if (row_ff >= eff_height) begin
            cmd_push       = 1'b1;
            cmd_ctl.kind   = KIND_DRAIN;
            cmd_ctl.has_up = (eff_height >= FH_BITS'(2));
            cmd_ctl.last   = at_row_end;
            if (at_row_end) begin
               col_in = '0;
               row_in = '0;
            end else begin
               col_in = col_next[COL_BITS-1:0];
            end
         end
      end

      if (csr_valid) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            frame_width_in = csr_data[FW_BITS-1:0];
            col_in         = '0;
            row_in         = '0;
         end else if (csr_index == CSR_FRAME_HEIGHT) begin
            frame_height_in = csr_data[FH_BITS-1:0];
            col_in          = '0;
            row_in          = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_RESET;
         frame_height_ff <= FH_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
      end
   end

endmodule

// ----- rtl/lpc_back.sv -----
// Back end: row buffers, neighbour compare and clip, result skid queue.
// Depends on lpc_pkg and lpc_queue; takes items from the command queue.
module lpc_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  lpc_pkg::lpc_ctl_type                head_ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0]        head_col,
   input  logic [((PIXEL_BITS < lpc_pkg::PIX_PORT_BITS) ? PIXEL_BITS :
                  lpc_pkg::PIX_PORT_BITS)-1:0] head_pix,
   output logic                                head_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [lpc_pkg::PIX_PORT_BITS-1:0]   rsp_pixel_out,
   output logic                                rsp_was_clipped,
   output logic                                rsp_frame_end
);

   import lpc_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int DATA_BITS = (PIXEL_BITS < PIX_PORT_BITS) ? PIXEL_BITS : PIX_PORT_BITS;
   localparam int RSP_BITS  = PIX_PORT_BITS + 2;

   logic [DATA_BITS-1:0] raw_mem  [MAX_WIDTH];
   logic [DATA_BITS-1:0] proc_mem [MAX_WIDTH];

   logic                 x_valid_ff;
   lpc_ctl_type          x_ctl_ff;
   logic [COL_BITS-1:0]  x_col_ff;
   logic [DATA_BITS-1:0] x_pix_ff;
   logic [DATA_BITS-1:0] rd_center_ff, rd_right_ff, rd_up_ff;
   logic                 fw_center_ff, fw_right_ff, fw_up_ff;
   logic                 fw_center_in, fw_right_in, fw_up_in;
   logic [DATA_BITS-1:0] fwd_raw_ff, fwd_proc_ff;
   logic [DATA_BITS-1:0] left_ff;

   logic [COL_BITS-1:0]  head_col_right;
   logic                 x_fire, load;
   logic                 x_writes_raw, x_writes_proc;
   logic [DATA_BITS-1:0] center, right_val, up_val, top, res;
   logic                 peak;
   logic                 out_push, out_full;
   logic [RSP_BITS-1:0]  out_data, rsp_data;

   assign x_writes_raw  = (x_ctl_ff.kind != KIND_DRAIN);
   assign x_writes_proc = (x_ctl_ff.kind != KIND_STORE);
   assign x_fire        = x_valid_ff & (~x_writes_proc | ~out_full);
   assign load          = head_valid & (~x_valid_ff | x_fire);
   assign head_pop      = load;
   assign out_push      = x_fire & x_writes_proc;
   assign head_col_right = head_col + 1'b1;

   // a read issued on the same edge as the older item's write sees stale data
   assign fw_center_in = x_fire & x_writes_raw & (x_col_ff == head_col);
   assign fw_right_in  = x_fire & x_writes_raw & (x_col_ff == head_col_right);
   assign fw_up_in     = x_fire & x_writes_proc & (x_col_ff == head_col);

   assign center    = fw_center_ff ? fwd_raw_ff  : rd_center_ff;
   assign right_val = fw_right_ff  ? fwd_raw_ff  : rd_right_ff;
   assign up_val    = fw_up_ff     ? fwd_proc_ff : rd_up_ff;

   // up and left are filtered values, down and right raw; absent ones impose nothing
   always_comb begin
      peak = 1'b1;
      top  = '0;
      if (x_ctl_ff.has_up) begin
         if (!(center > up_val)) peak = 1'b0;
         if (up_val > top) top = up_val;
      end
      if (x_ctl_ff.kind == KIND_PIXEL) begin
         if (!(center > x_pix_ff)) peak = 1'b0;
         if (x_pix_ff > top) top = x_pix_ff;
      end
      if (x_ctl_ff.has_left) begin
         if (!(center > left_ff)) peak = 1'b0;
         if (left_ff > top) top = left_ff;
      end
      if (x_ctl_ff.has_right) begin
         if (!(center > right_val)) peak = 1'b0;
         if (right_val > top) top = right_val;
      end
      res = peak ? top : center;
   end

   assign out_data = {PIX_PORT_BITS'(res), peak, x_ctl_ff.last};

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else if (load) begin
         x_valid_ff <= 1'b1;
      end else if (x_fire) begin
         x_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ctl_ff     <= head_ctl;
         x_col_ff     <= head_col;
         x_pix_ff     <= head_pix;
         fw_center_ff <= fw_center_in;
         fw_right_ff  <= fw_right_in;
         fw_up_ff     <= fw_up_in;
         fwd_raw_ff   <= x_pix_ff;
         fwd_proc_ff  <= res;
      end
      if (out_push) begin
         left_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (x_fire && x_writes_raw) begin
         raw_mem[x_col_ff] <= x_pix_ff;
      end
      if (load) begin
         rd_center_ff <= raw_mem[head_col];
         rd_right_ff  <= raw_mem[head_col_right];
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         proc_mem[x_col_ff] <= res;
      end
      if (load) begin
         rd_up_ff <= proc_mem[head_col];
      end
   end

   lpc_queue #(
      .DEPTH (RSP_Q_DEPTH),
      .WIDTH (RSP_BITS)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_pixel_out   = rsp_data[RSP_BITS-1:2];
   assign rsp_was_clipped = rsp_data[1];
   assign rsp_frame_end   = rsp_data[0];

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (x_valid_ff && !x_fire) |=> (x_valid_ff && $stable(x_col_ff) && $stable(x_ctl_ff)))
      else $error("stalled work item changed");

   a_fwd_exclusive: assert property (@(posedge clock) disable iff (reset)
      x_valid_ff |-> !(fw_center_ff && fw_right_ff))
      else $error("center and right forwarded from one write");

   a_last_on_drain: assert property (@(posedge clock) disable iff (reset)
      (x_fire && x_ctl_ff.last) |-> (x_ctl_ff.kind == KIND_DRAIN))
      else $error("frame end flagged on a non-drain beat");

endmodule

// ----- rtl/local_peak_clip_filter.sv -----
// Local peak clip filter, top level: front end, command queue, back end.
// Depends on lpc_pkg, lpc_front, lpc_queue and lpc_back.
//
// Clips every pixel that is strictly above all of its existing four neighbours
// down to the largest of them (up and left taken as filtered values, down and
// right as raw). Results run one row behind the input: row zero only fills the
// raw line buffer, each later pixel releases the pixel above it, and once the
// whole frame is in, one drain beat per pixel flushes the last row; frame_end
// marks the final result. Pixels past a full frame and early drains are
// dropped with no result. A write to either csr register restarts the frame
// position; line buffer contents are kept and need no clearing after reset.
// Throughput is one beat per clock while results are popped; a full result
// queue stalls the back end. The front end classifies a beat in the cycle it
// is taken, and the back end reads both line buffers (raw at two columns,
// filtered at one) into registers as it takes a beat from the command queue,
// then compares and writes back from its work register, with write-to-read
// forwarding between neighbouring beats.
module local_peak_clip_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_operation,
   input  logic [lpc_pkg::PIX_PORT_BITS-1:0]   req_pixel_in,
   output logic                                empty,
   input  logic                                pop,
   output logic [lpc_pkg::PIX_PORT_BITS-1:0]   rsp_pixel_out,
   output logic                                rsp_was_clipped,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lpc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   import lpc_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int DATA_BITS = (PIXEL_BITS < PIX_PORT_BITS) ? PIXEL_BITS : PIX_PORT_BITS;
   localparam int CTL_BITS  = $bits(lpc_ctl_type);
   localparam int CMD_BITS  = CTL_BITS + COL_BITS + DATA_BITS;

   logic                 cmd_push, cmd_full, cmd_empty, cmd_pop;
   lpc_ctl_type          cmd_ctl, head_ctl;
   logic [COL_BITS-1:0]  cmd_col, head_col;
   logic [DATA_BITS-1:0] cmd_pix, head_pix;
   logic [CMD_BITS-1:0]  cmd_word, head_word;

   assign full = cmd_full;

   lpc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (push),
      .req_operation (req_operation),
      .req_pixel_in  (req_pixel_in),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd_ctl       (cmd_ctl),
      .cmd_col       (cmd_col),
      .cmd_pix       (cmd_pix)
   );

   assign cmd_word = {cmd_ctl, cmd_col, cmd_pix};

   lpc_queue #(
      .DEPTH (CMD_Q_DEPTH),
      .WIDTH (CMD_BITS)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_word),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (head_word),
      .empty     (cmd_empty)
   );

   assign head_ctl = lpc_ctl_type'(head_word[CMD_BITS-1 -: CTL_BITS]);
   assign head_col = head_word[DATA_BITS +: COL_BITS];
   assign head_pix = head_word[DATA_BITS-1:0];

   lpc_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (~cmd_empty),
      .head_ctl        (head_ctl),
      .head_col        (head_col),
      .head_pix        (head_pix),
      .head_pop        (cmd_pop),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_was_clipped (rsp_was_clipped),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

// ----- tb/lpc_clip_checker.sv -----
// Checker for local_peak_clip_filter: watches the req, rsp and csr channels,
// predicts every filtered pixel and compares it with the beat that comes out.
// Depends on lpc_pkg; instantiated by testbench beside the block.
module lpc_clip_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic                               full,
   input  logic                               req_operation,
   input  logic [lpc_pkg::PIX_PORT_BITS-1:0]  req_pixel_in,
   input  logic                               empty,
   input  logic                               pop,
   input  logic [lpc_pkg::PIX_PORT_BITS-1:0]  rsp_pixel_out,
   input  logic                               rsp_was_clipped,
   input  logic                               rsp_frame_end,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [lpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lpc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 fail_count,
   output int                                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import lpc_pkg::*;

   localparam int LINE_LEN   = 1024;
   localparam int SHOW_LIMIT = 10;

   typedef struct packed {
      logic [PIX_PORT_BITS-1:0] pixel;
      logic                     clipped;
      logic                     last;
   } clip_beat_type;

   logic [PIX_PORT_BITS-1:0] raw_line  [LINE_LEN];
   logic [PIX_PORT_BITS-1:0] filt_line [LINE_LEN];
   logic [PIX_PORT_BITS-1:0] left_filt;
   int unsigned              col;
   int unsigned              row;
   logic [FW_BITS-1:0]       width_cfg;
   logic [FH_BITS-1:0]       height_cfg;
   clip_beat_type            clip_expect_q [$];

   function automatic int unsigned active_width();
      if (width_cfg == 0) return 1;
      if (width_cfg > LINE_LEN) return LINE_LEN;
      return int'(width_cfg);
   endfunction

   function automatic int unsigned active_height();
      return (height_cfg == 0) ? 1 : int'(height_cfg);
   endfunction

   function automatic void restart_position();
      left_filt = '0;
      col       = 0;
      row       = 0;
   endfunction

   // up and left are filtered values, down and right raw; absent neighbours don't count
   function automatic logic [PIX_PORT_BITS-1:0] clip_pixel(
         input int unsigned c, input int unsigned w, input bit has_up, input bit has_down,
         input logic [PIX_PORT_BITS-1:0] below, output bit peak);
      logic [PIX_PORT_BITS-1:0] center;
      logic [PIX_PORT_BITS-1:0] top;
      logic [PIX_PORT_BITS-1:0] nb;
      center = raw_line[c];
      top    = '0;
      peak   = 1'b1;
      if (has_up) begin
         nb = filt_line[c];
         if (center <= nb) peak = 1'b0;
         if (nb > top) top = nb;
      end
      if (has_down) begin
         if (center <= below) peak = 1'b0;
         if (below > top) top = below;
      end
      if (c >= 1) begin
         if (center <= left_filt) peak = 1'b0;
         if (left_filt > top) top = left_filt;
      end
      if (c + 1 < w) begin
         nb = raw_line[c + 1];
         if (center <= nb) peak = 1'b0;
         if (nb > top) top = nb;
      end
      return peak ? top : center;
   endfunction

   // returns 1 when the beat releases a filtered pixel
   function automatic bit advance_stream(input logic op, input logic [PIX_PORT_BITS-1:0] pix,
                                         output clip_beat_type res);
      int unsigned              w;
      int unsigned              h;
      int unsigned              c;
      bit                       peak;
      logic [PIX_PORT_BITS-1:0] val;
      w   = active_width();
      h   = active_height();
      c   = (col >= w) ? 0 : col;
      res = '0;
      if (op == OP_PIXEL) begin
         if (row >= h) return 1'b0;
         if (row == 0) begin
            raw_line[c] = pix;
            col = c + 1;
            if (col >= w) begin
               col = 0;
               row = 1;
            end
            return 1'b0;
         end
         val = clip_pixel(c, w, row >= 2, 1'b1, pix, peak);
         filt_line[c] = val;
         raw_line[c]  = pix;
         left_filt    = val;
         col = c + 1;
         if (col >= w) begin
            col       = 0;
            row       = row + 1;
            left_filt = '0;
         end
      end else begin
         if (row < h) return 1'b0;
         val = clip_pixel(c, w, h >= 2, 1'b0, '0, peak);
         filt_line[c] = val;
         left_filt    = val;
         col = c + 1;
         if (col >= w) begin
            res.last = 1'b1;
            restart_position();
         end
      end
      res.pixel   = val;
      res.clipped = peak;
      return 1'b1;
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= SHOW_LIMIT) $display("%s", what);
   endfunction

   always @(posedge clock) begin : watch
      clip_beat_type want;
      clip_beat_type got;
      if (reset) begin
         width_cfg  = FW_RESET;
         height_cfg = FH_RESET;
         restart_position();
         clip_expect_q.delete();
         fail_count = 0;
      end else begin
         if (pop && !empty) begin
            got = '{rsp_pixel_out, rsp_was_clipped, rsp_frame_end};
            if (clip_expect_q.size() == 0) begin
               note_failure($sformatf("unexpected rsp beat: pixel=%h clip=%0b end=%0b",
                                      got.pixel, got.clipped, got.last));
            end else begin
               want = clip_expect_q.pop_front();
               if (got.pixel !== want.pixel || got.clipped !== want.clipped ||
                   got.last !== want.last)
                  note_failure($sformatf(
                     "rsp mismatch: want pixel=%h clip=%0b end=%0b got pixel=%h clip=%0b end=%0b",
                     want.pixel, want.clipped, want.last, got.pixel, got.clipped, got.last));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FRAME_WIDTH) begin
               width_cfg = csr_data[FW_BITS-1:0];
               restart_position();
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               height_cfg = csr_data[FH_BITS-1:0];
               restart_position();
            end
         end
         if (push && !full) begin
            if (advance_stream(req_operation, req_pixel_in, want))
               clip_expect_q = {clip_expect_q, want};
         end
      end
      outstanding = clip_expect_q.size();
   end

endmodule

// ----- tb/testbench.sv -----
// Top of the local_peak_clip_filter testbench: clock, reset, pixel and drain
// stimulus, csr writes, rsp back-pressure and the verdict.
// Depends on lpc_pkg, local_peak_clip_filter and lpc_clip_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lpc_pkg::*;

   localparam int unsigned MAX_LINE      = 1024;
   localparam int unsigned PHASE_ITEMS   = 170;
   localparam int unsigned LONG_STALL    = 120;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned NOISE_PCT     = 4;
   localparam int unsigned NO_CUT        = 32'hFFFF_FFFF;
   localparam int unsigned TIME_LIMIT_NS = 5_000_000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef enum {SPREAD_TIGHT, SPREAD_FULL, SPREAD_TOP, SPREAD_BYTE} pixel_spread_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      push;
   logic                      full;
   logic                      req_operation;
   logic [PIX_PORT_BITS-1:0]  req_pixel_in;
   logic                      empty;
   logic                      pop;
   logic [PIX_PORT_BITS-1:0]  rsp_pixel_out;
   logic                      rsp_was_clipped;
   logic                      rsp_frame_end;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        fail_count;
   int                        outstanding;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned stall_requests;
   int unsigned items_done;

   always #5 clock = ~clock;

   local_peak_clip_filter dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_operation   (req_operation),
      .req_pixel_in    (req_pixel_in),
      .empty           (empty),
      .pop             (pop),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_was_clipped (rsp_was_clipped),
      .rsp_frame_end   (rsp_frame_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   lpc_clip_checker clip_check (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_operation   (req_operation),
      .req_pixel_in    (req_pixel_in),
      .empty           (empty),
      .pop             (pop),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_was_clipped (rsp_was_clipped),
      .rsp_frame_end   (rsp_frame_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   function automatic logic [PIX_PORT_BITS-1:0] next_pixel(input pixel_spread_type spread);
      case (spread)
         SPREAD_TIGHT: return $urandom_range(3, 0);
         SPREAD_TOP:   return 32'hFFFF_FFFC | $urandom_range(3, 0);
         SPREAD_BYTE:  return $urandom_range(255, 0);
         default:      return $urandom;
      endcase
   endfunction

   // push stays high on return so back-to-back beats never drop it
   task automatic send_beat(input logic op, input logic [PIX_PORT_BITS-1:0] pix);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push          <= 1'b1;
      req_operation <= op;
      req_pixel_in  <= pix;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   // csr_valid stays high on return; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic configure(input int unsigned w_cfg, input int unsigned h_cfg);
      write_csr(CSR_FRAME_WIDTH, {5'($urandom), 11'(w_cfg)});
      write_csr(CSR_FRAME_HEIGHT, 16'(h_cfg));
      csr_valid <= 1'b0;
   endtask

   // wait for every expected rsp beat, then let dropped beats clear the pipe
   task automatic settle();
      push      <= 1'b0;
      csr_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one frame: pixels then drains, with stray drains/pixels mixed in; cut aborts it early
   task automatic run_frame(input int unsigned w_cfg, input int unsigned h_cfg,
                            input pixel_spread_type spread, input int unsigned cut);
      int unsigned w;
      int unsigned h;
      int unsigned sent;
      bit          in_pixels;
      w    = (w_cfg == 0) ? 1 : (w_cfg > MAX_LINE ? MAX_LINE : w_cfg);
      h    = (h_cfg == 0) ? 1 : h_cfg;
      sent = 0;
      configure(w_cfg, h_cfg);
      for (int unsigned i = 0; i < w * h + w && sent < cut; i++) begin
         in_pixels = (i < w * h);
         if ($urandom_range(99, 0) < NOISE_PCT)
            send_beat(in_pixels ? OP_DRAIN : OP_PIXEL, $urandom);
         send_beat(in_pixels ? OP_PIXEL : OP_DRAIN, in_pixels ? next_pixel(spread) : $urandom);
         sent++;
      end
      items_done += sent;
      settle();
   endtask

   // rsp side: random pops, plus a long hold-off whenever one is requested
   initial begin : receiver
      int unsigned stalls_served;
      stalls_served = 0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_requests != stalls_served) begin
            stalls_served++;
            pop <= 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
         end else begin
            pop <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int unsigned      pick;
      int unsigned      w_cfg;
      int unsigned      h_cfg;
      int unsigned      cut;
      int unsigned      phase_goal;
      pixel_spread_type spread;
      reset          = 1'b1;
      push           = 1'b0;
      req_operation  = OP_PIXEL;
      req_pixel_in   = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_FRAME_WIDTH;
      csr_data       = '0;
      send_idle_pct  = 13;
      recv_idle_pct  = 62;
      stall_requests = 0;
      items_done     = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lone pixel, with an early drain before it and a stray pixel after it
      configure(0, 0);
      send_beat(OP_DRAIN, 32'h0);
      send_beat(OP_PIXEL, 32'hFFFF_FFFF);
      send_beat(OP_PIXEL, 32'h1234_5678);
      send_beat(OP_DRAIN, 32'hFFFF_FFFF);
      settle();

      // 3x2 with field extremes and an early drain mid-frame
      configure(3, 2);
      send_beat(OP_PIXEL, 32'h0);
      send_beat(OP_PIXEL, 32'hFFFF_FFFF);
      send_beat(OP_PIXEL, 32'h5);
      send_beat(OP_DRAIN, 32'h0);
      send_beat(OP_PIXEL, 32'hFFFF_FFFF);
      send_beat(OP_PIXEL, 32'h0);
      send_beat(OP_PIXEL, 32'h7);
      repeat (3) send_beat(OP_DRAIN, 32'h0);
      settle();

      // flat 2x3: ties are never peaks
      configure(2, 3);
      repeat (6) send_beat(OP_PIXEL, 32'h9);
      repeat (2) send_beat(OP_DRAIN, 32'h0);
      settle();

      // register extremes: tallest and widest frames, all abandoned early
      configure(1, 65535);
      for (int i = 0; i < 6; i++) send_beat(OP_PIXEL, next_pixel(SPREAD_TIGHT));
      send_beat(OP_DRAIN, 32'h0);
      settle();
      run_frame(MAX_LINE, 1, SPREAD_BYTE, 40);
      run_frame(2047, 1, SPREAD_FULL, 60);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 62 : 0;
         recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 13 : 0;
         phase_goal    = items_done + PHASE_ITEMS;
         // csr_valid stays high into the frame setup that follows
         write_csr(CSR_SPARE, $urandom);
         if (phase == 2) begin
            // rsp side blocks while the sender keeps going: req side must back up
            stall_requests++;
            run_frame(16, 4, SPREAD_FULL, NO_CUT);
         end
         while (items_done < phase_goal) begin
            pick  = $urandom_range(99, 0);
            w_cfg = (pick < 70) ? $urandom_range(6, 1) : (pick < 92) ? $urandom_range(24, 7) : 0;
            pick  = $urandom_range(99, 0);
            h_cfg = (pick < 70) ? $urandom_range(4, 1) : (pick < 92) ? $urandom_range(9, 5) : 0;
            spread = pixel_spread_type'($urandom_range(3, 0));
            cut = ($urandom_range(99, 0) < 10) ? $urandom_range((w_cfg + 1) * (h_cfg + 1), 0)
                                               : NO_CUT;
            run_frame(w_cfg, h_cfg, spread, cut);
         end
      end

      settle();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #(TIME_LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
